[rtl/core/ufmr_pkg.sv]
// Shared types and constants for the union-find engine.
// Holds the controller state enum and the command/status structs.
// No dependencies.
package ufmr_pkg;

	// Node id width and the number of ids it can name
	localparam int ID_W    = 8;
	localparam int ID_SPAN = 1 << ID_W;

	typedef logic [ID_W-1:0] node_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_CHASE,
		ST_COMP,
		ST_PASS_END,
		ST_LINK,
		ST_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;        // capture the accepted request
		logic begin_walk;  // cur <= walk node, read its link
		logic root_x;      // root <= walk node (out-of-range node)
		logic step_chase;  // cur <= link, read next link
		logic set_root;    // root <= cur
		logic step_comp;   // parent[cur] <= root, cur <= link, read next link
		logic save_ra;     // keep root of node_a, clear merged
		logic pass_b;      // second walk uses node_b
		logic link;        // hang larger root under smaller one
		logic emit;        // load the response register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic x_in;        // walk node has a table entry
		logic at_root;     // link just read points to itself
		logic pass_b;      // second walk in progress
		logic unite;       // request is a unite
		logic can_merge;   // both nodes in range and roots differ
		logic out_busy;    // response register full and not taken
	} dp_sts_t;

endpackage

[rtl/core/ufmr_req_if.sv]
// Request channel of the union-find engine: valid/ready plus payload.
// Depends on ufmr_pkg.
interface ufmr_req_if;
	logic                valid;
	logic                ready;
	logic                command;
	ufmr_pkg::node_t     node_a;
	ufmr_pkg::node_t     node_b;

	modport source (output valid, command, node_a, node_b, input ready);
	modport sink   (input valid, command, node_a, node_b, output ready);
endinterface

[rtl/core/ufmr_rsp_if.sv]
// Response channel of the union-find engine: valid/ready plus payload.
// Depends on ufmr_pkg.
interface ufmr_rsp_if;
	logic                valid;
	logic                ready;
	ufmr_pkg::node_t     root;
	logic                merged;

	modport source (output valid, root, merged, input ready);
	modport sink   (input valid, root, merged, output ready);
endinterface

[rtl/core/ufmr_ctrl.sv]
// Controller of the union-find engine: sequences link chase, path
// compression, linking and response. Depends on ufmr_pkg.
module ufmr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  ufmr_pkg::dp_sts_t  sts,
	output ufmr_pkg::dp_cmd_t  cmd
);

	ufmr_pkg::state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ufmr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ufmr_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ufmr_pkg::ST_START;
				end
			end
			ufmr_pkg::ST_START: begin
				cmd.begin_walk = 1'b1;
				cmd.root_x     = 1'b1;
				state_d = sts.x_in ? ufmr_pkg::ST_CHASE : ufmr_pkg::ST_PASS_END;
			end
			ufmr_pkg::ST_CHASE: begin
				if (sts.at_root) begin
					// root found: restart at the walk node to compress
					cmd.set_root   = 1'b1;
					cmd.begin_walk = 1'b1;
					state_d        = ufmr_pkg::ST_COMP;
				end else begin
					cmd.step_chase = 1'b1;
				end
			end
			ufmr_pkg::ST_COMP: begin
				if (sts.at_root) begin
					state_d = ufmr_pkg::ST_PASS_END;
				end else begin
					cmd.step_comp = 1'b1;
				end
			end
			ufmr_pkg::ST_PASS_END: begin
				if (!sts.pass_b) begin
					cmd.save_ra = 1'b1;
					if (sts.unite) begin
						cmd.pass_b = 1'b1;
						state_d    = ufmr_pkg::ST_START;
					end else begin
						state_d = ufmr_pkg::ST_DONE;
					end
				end else begin
					state_d = sts.can_merge ? ufmr_pkg::ST_LINK : ufmr_pkg::ST_DONE;
				end
			end
			ufmr_pkg::ST_LINK: begin
				cmd.link = 1'b1;
				state_d  = ufmr_pkg::ST_DONE;
			end
			ufmr_pkg::ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = ufmr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ufmr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/core/ufmr_dp.sv]
// Datapath of the union-find engine: parent table memory with per-entry
// valid bits, walk registers and the response register. Depends on ufmr_pkg.
module ufmr_dp #(
	parameter int NODES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ufmr_pkg::dp_cmd_t  cmd,
	output ufmr_pkg::dp_sts_t  sts,
	input  logic               in_command,
	input  ufmr_pkg::node_t    in_node_a,
	input  ufmr_pkg::node_t    in_node_b,
	output logic               out_valid,
	input  logic               out_ready,
	output ufmr_pkg::node_t    out_root,
	output logic               out_merged
);

	// Only ids an 8-bit field can name get a table entry
	localparam int DEPTH = (NODES < ufmr_pkg::ID_SPAN) ? NODES : ufmr_pkg::ID_SPAN;
	localparam int AW    = $clog2(DEPTH);

	// Request and walk registers
	logic            cmd_q;
	ufmr_pkg::node_t a_q, b_q, cur_q, root_q, ra_q;
	logic            merged_q;
	logic            pass_q;

	// Response register
	logic            out_vld_q;
	ufmr_pkg::node_t out_root_q;
	logic            out_merged_q;

	// Parent table, its valid bits and the registered read
	ufmr_pkg::node_t mem_q [DEPTH];
	logic [DEPTH-1:0] vld_q;
	ufmr_pkg::node_t mem_rd_q;
	logic            rvld_q;
	logic [AW-1:0]   raddr_q;

	ufmr_pkg::node_t x, rd_data, lo, hi, wdata;
	logic [AW-1:0]   raddr, waddr;
	logic            rd_en, wen;
	logic            x_in, a_in, b_in;

	// Walk node and range checks
	assign x    = pass_q ? b_q : a_q;
	assign x_in = (32'(x) < NODES);
	assign a_in = (32'(a_q) < NODES);
	assign b_in = (32'(b_q) < NODES);

	// An entry never written still holds its own index
	assign rd_data = rvld_q ? mem_rd_q : ufmr_pkg::ID_W'(raddr_q);

	// Read port: start of a walk or follow the link just read
	assign rd_en = cmd.begin_walk | cmd.step_chase | cmd.step_comp;
	assign raddr = cmd.begin_walk ? x[AW-1:0] : rd_data[AW-1:0];

	// Write port: compression rewrite or root link
	assign lo    = (ra_q < root_q) ? ra_q : root_q;
	assign hi    = (ra_q < root_q) ? root_q : ra_q;
	assign wen   = cmd.step_comp | cmd.link;
	assign waddr = cmd.step_comp ? cur_q[AW-1:0] : hi[AW-1:0];
	assign wdata = cmd.step_comp ? root_q : lo;

	// Table storage and registered read
	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			mem_rd_q <= mem_q[raddr];
			rvld_q   <= vld_q[raddr];
			raddr_q  <= raddr;
		end
	end

	// Valid bits: cleared by reset, set on first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wen) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// Request capture and walk state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= in_command;
			a_q   <= in_node_a;
			b_q   <= in_node_b;
		end
		if (cmd.begin_walk) begin
			cur_q <= x;
		end else if (cmd.step_chase || cmd.step_comp) begin
			cur_q <= rd_data;
		end
		if (cmd.set_root) begin
			root_q <= cur_q;
		end else if (cmd.root_x) begin
			root_q <= x;
		end
		if (cmd.save_ra) begin
			ra_q     <= root_q;
			merged_q <= 1'b0;
		end else if (cmd.link) begin
			ra_q     <= lo;
			merged_q <= 1'b1;
		end
	end

	// Second walk flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q <= 1'b0;
		end else if (cmd.load) begin
			pass_q <= 1'b0;
		end else if (cmd.pass_b) begin
			pass_q <= 1'b1;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_root_q   <= ra_q;
			out_merged_q <= merged_q;
		end
	end

	assign out_valid  = out_vld_q;
	assign out_root   = out_root_q;
	assign out_merged = out_merged_q;

	// Status to the controller
	assign sts.x_in      = x_in;
	assign sts.at_root   = (rd_data == cur_q);
	assign sts.pass_b    = pass_q;
	assign sts.unite     = cmd_q;
	assign sts.can_merge = a_in & b_in & (ra_q != root_q);
	assign sts.out_busy  = out_vld_q & ~out_ready;

endmodule

[rtl/core/union_find_min_root.sv]
// Union-find engine with full path compression; every root is the least id
// of its set. One request is worked at a time. The parent table has a single
// read and a single write port, so a walk follows one link per cycle: a find
// chases links from its node to the root, then walks them again to hang each
// node under that root, and raises its response after both walks. A find on
// an id with no table entry responds without a walk. A unite responds after
// its two finds, plus a link step when it links two sets. Compression keeps
// later walks short for repeated requests. A response that is not taken holds
// the engine before its next response until the output register frees up.
// The table needs no clearing pass after reset: per-entry valid bits make an
// unwritten entry point to itself. A new request is taken while the last
// response still waits in its output register.
module union_find_min_root #(
	parameter int NODES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	ufmr_req_if.sink    req,
	ufmr_rsp_if.source  rsp
);

	ufmr_pkg::dp_cmd_t cmd;
	ufmr_pkg::dp_sts_t sts;

	// Sequencer
	ufmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Table and walk registers
	ufmr_dp #(
		.NODES (NODES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_command (req.command),
		.in_node_a  (req.node_a),
		.in_node_b  (req.node_b),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_root   (rsp.root),
		.out_merged (rsp.merged)
	);

endmodule

[rtl/core/ufmr_chk.sv]
// Port-level checks for the union-find engine, bound to its top level.
// Depends on ufmr_pkg and the two channel interfaces.
module ufmr_chk (
	input logic         clk,
	input logic         arst_n,
	ufmr_req_if.sink    req,
	ufmr_rsp_if.source  rsp
);

	logic            req_acc, rsp_acc;
	logic [1:0]      cnt_q;
	logic            hd_cmd_q, tl_cmd_q;
	ufmr_pkg::node_t hd_a_q, tl_a_q;

	assign req_acc = req.valid & req.ready;
	assign rsp_acc = rsp.valid & rsp.ready;

	// Outstanding request count (the engine holds at most two)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (req_acc && !rsp_acc) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (!req_acc && rsp_acc) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	// Two-entry record of outstanding requests, oldest at head
	always_ff @(posedge clk) begin
		case ({req_acc, rsp_acc})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					hd_cmd_q <= req.command;
					hd_a_q   <= req.node_a;
				end else begin
					tl_cmd_q <= req.command;
					tl_a_q   <= req.node_a;
				end
			end
			2'b01: begin
				hd_cmd_q <= tl_cmd_q;
				hd_a_q   <= tl_a_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					hd_cmd_q <= req.command;
					hd_a_q   <= req.node_a;
				end else begin
					hd_cmd_q <= tl_cmd_q;
					hd_a_q   <= tl_a_q;
					tl_cmd_q <= req.command;
					tl_a_q   <= req.node_a;
				end
			end
			default: begin
			end
		endcase
	end

	// A stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.root) && $stable(rsp.merged))
		else $error("response changed while stalled");

	// No response without a request
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> cnt_q != 2'd0)
		else $error("response with no outstanding request");

	// A find never reports a merge
	a_find_no_merge: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc && !hd_cmd_q |-> !rsp.merged)
		else $error("find reported a merge");

	// The root is the least id of the set, so never above node_a
	a_root_least: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_acc |-> rsp.root <= hd_a_q)
		else $error("root above the looked-up node");

endmodule

bind union_find_min_root ufmr_chk u_ufmr_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
